// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the heap block.
// No dependencies; defining SYNTH turns every check into an empty line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHK_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ALWAYS(lbl, prop, msg)
`define CHK_RESET(lbl, prop, msg)
`endif
`endif

// ===== rtl/bmh_pkg.sv =====
// Shared constants and types of the binary max-heap block.
// No dependencies; imported by the controller and the top level.
package bmh_pkg;

  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/bmh_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies; holds the key store of the heap.
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/bmh_ctrl.sv =====
// Sequencer of the heap: sift-up and sift-down walks over the key store RAM.
// Depends on bmh_pkg and assert_macros.svh; drives one bmh_ram instance.
`include "assert_macros.svh"

module bmh_ctrl import bmh_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 op,
  input  logic [KEY_WIDTH-1:0] key,
  output logic                 busy,
  output logic                 done,
  output logic [KEY_WIDTH-1:0] top_key,
  output logic [CW-1:0]        entries,
  output logic [1:0]           status,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [KEY_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]        mem_raddr_a,
  output logic [AW-1:0]        mem_raddr_b,
  input  logic [KEY_WIDTH-1:0] mem_rdata_a,
  input  logic [KEY_WIDTH-1:0] mem_rdata_b
);

  localparam int PW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_UP      = 6'b000010,
    S_UP_PUT  = 6'b000100,
    S_DN_LAST = 6'b001000,
    S_DN      = 6'b010000,
    S_DN_PUT  = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] kreg, kreg_next;
  logic [KEY_WIDTH-1:0] dtop, dtop_next;
  logic [KEY_WIDTH-1:0] root;
  logic                 done_next;
  logic [KEY_WIDTH-1:0] top_next;
  logic [CW-1:0]        entries_next;
  logic [1:0]           status_next;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    q = p - 1'b1;
    return q >> 1;
  endfunction

  function automatic logic [PW-1:0] lchild_of(input logic [AW-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  logic [PW-1:0]        n_ext;
  logic [AW-1:0]        up_par;
  logic [PW-1:0]        lpos, rpos, bpos, nl;
  logic                 pick_r;
  logic [KEY_WIDTH-1:0] bval;

  assign busy = (state != S_IDLE);

  always_comb begin
    n_ext  = PW'(count);
    up_par = parent_of(pos);
    lpos   = lchild_of(pos);
    rpos   = lpos + 1'b1;
    pick_r = (rpos < n_ext) && (mem_rdata_b > mem_rdata_a);
    bpos   = pick_r ? rpos : lpos;
    bval   = pick_r ? mem_rdata_b : mem_rdata_a;
    nl     = lchild_of(bpos[AW-1:0]);
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    kreg_next    = kreg;
    dtop_next    = dtop;
    done_next    = 1'b0;
    top_next     = top_key;
    entries_next = entries;
    status_next  = status;
    mem_we       = 1'b0;
    mem_waddr    = pos;
    mem_wdata    = kreg;
    mem_raddr_a  = parent_of(up_par);
    mem_raddr_b  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              done_next    = 1'b1;
              top_next     = root;
              entries_next = count;
              status_next  = ST_FULL;
            end else if (count == '0) begin
              mem_we       = 1'b1;
              mem_waddr    = '0;
              mem_wdata    = key;
              count_next   = count + 1'b1;
              done_next    = 1'b1;
              top_next     = key;
              entries_next = count_next;
              status_next  = ST_DONE;
            end else begin
              kreg_next   = key;
              pos_next    = count[AW-1:0];
              count_next  = count + 1'b1;
              mem_raddr_a = parent_of(count[AW-1:0]);
              state_next  = S_UP;
            end
          end else begin
            if (count == '0) begin
              done_next    = 1'b1;
              top_next     = '0;
              entries_next = count;
              status_next  = ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
              dtop_next  = root;
              if (count == CW'(1)) begin
                done_next    = 1'b1;
                top_next     = root;
                entries_next = count_next;
                status_next  = ST_DONE;
              end else begin
                mem_raddr_a = AW'(count - 1'b1);
                state_next  = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (kreg > mem_rdata_a) begin
          mem_wdata = mem_rdata_a;
          pos_next  = up_par;
          if (up_par == '0) begin
            state_next = S_UP_PUT;
          end
        end else begin
          done_next    = 1'b1;
          top_next     = root;
          entries_next = count;
          status_next  = ST_DONE;
          state_next   = S_IDLE;
        end
      end
      S_UP_PUT: begin
        mem_we       = 1'b1;
        done_next    = 1'b1;
        top_next     = kreg;
        entries_next = count;
        status_next  = ST_DONE;
        state_next   = S_IDLE;
      end
      S_DN_LAST: begin
        kreg_next = mem_rdata_a;
        pos_next  = '0;
        if (count == CW'(1)) begin
          mem_we       = 1'b1;
          mem_waddr    = '0;
          mem_wdata    = mem_rdata_a;
          done_next    = 1'b1;
          top_next     = dtop;
          entries_next = count;
          status_next  = ST_DONE;
          state_next   = S_IDLE;
        end else begin
          mem_raddr_a = AW'(1);
          mem_raddr_b = AW'(2);
          state_next  = S_DN;
        end
      end
      S_DN: begin
        mem_we = 1'b1;
        if (bval > kreg) begin
          mem_wdata   = bval;
          pos_next    = bpos[AW-1:0];
          mem_raddr_a = nl[AW-1:0];
          mem_raddr_b = AW'(nl + 1'b1);
          if (nl >= n_ext) begin
            state_next = S_DN_PUT;
          end
        end else begin
          done_next    = 1'b1;
          top_next     = dtop;
          entries_next = count;
          status_next  = ST_DONE;
          state_next   = S_IDLE;
        end
      end
      S_DN_PUT: begin
        mem_we       = 1'b1;
        done_next    = 1'b1;
        top_next     = dtop;
        entries_next = count;
        status_next  = ST_DONE;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    pos     <= pos_next;
    kreg    <= kreg_next;
    dtop    <= dtop_next;
    top_key <= top_next;
    entries <= entries_next;
    status  <= status_next;
    if (mem_we && mem_waddr == '0) begin
      root <= mem_wdata;
    end
  end

  `CHK_RESET(a_reset_idle, rst |=> state == S_IDLE && !done, "reset did not idle the sequencer")
  `CHK_ALWAYS(a_count_range, count <= CW'(CAPACITY), "entry count beyond capacity")
  `CHK_ALWAYS(a_accept_moves, start && !busy |=> busy || done, "accepted beat was dropped")
  `CHK_ALWAYS(a_root_copy, mem_we && mem_waddr == '0 |=> root == $past(mem_wdata), "root copy stale")
  `CHK_ALWAYS(a_full_flag, done && status == ST_FULL |-> entries == CW'(CAPACITY), "full flag without full heap")

endmodule

// ===== rtl/binary_max_heap_top.sv =====
// A refused beat, an insert into an empty heap or a delete that leaves it empty
// gives its result in the cycle after start; otherwise the walk moves one tree level
// per cycle, set by the single write port of the key store RAM.
// One beat at a time; busy rises at the accepting edge of a walking beat until its result.
// Synchronous active-high reset empties the heap; the receiver cannot stall the result.
module binary_max_heap_top import bmh_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [KEY_WIDTH-1:0] key,
  output logic                 done,
  output logic [KEY_WIDTH-1:0] top_key,
  output logic [CW-1:0]        entries,
  output logic [1:0]           status
);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr_a;
  logic [AW-1:0]        mem_raddr_b;
  logic [KEY_WIDTH-1:0] mem_rdata_a;
  logic [KEY_WIDTH-1:0] mem_rdata_b;

  bmh_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .op          (op),
    .key         (key),
    .busy        (busy),
    .done        (done),
    .top_key     (top_key),
    .entries     (entries),
    .status      (status),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  bmh_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule
